>>> sv/linear_probe_hash_table_assert.svh
// Assertion macros shared by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lpht_pkg.sv
// Types and constants of the linear probing hash table.
package lpht_pkg;

    localparam logic [1:0] ACT_SET = 2'd0;
    localparam logic [1:0] ACT_GET = 2'd1;
    localparam logic [1:0] ACT_DEL = 2'd2;

    localparam logic [1:0] STS_DONE      = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    // Slot mark: bit 0 occupied, bit 1 tombstone
    localparam logic [1:0] MARK_EMPTY = 2'b00;
    localparam logic [1:0] MARK_OCC   = 2'b01;
    localparam logic [1:0] MARK_TOMB  = 2'b10;

    localparam int PADDR_W = 3;
    localparam logic REG_LOAD_LIMIT = 1'b0;
    localparam logic [7:0] LOAD_LIMIT_RST = 8'd192;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [63:0] value_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_new;
        logic        found;
        logic [63:0] value_out;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        CMT_NONE,
        CMT_VALUE,
        CMT_INSERT,
        CMT_DELETE
    } commit_op_t;

endpackage

>>> sv/linear_probe_hash_table.sv
// Open-addressing key/value table with linear probing and tombstones.
//
//  channel | dir | handshake          | beat
//  req     | in  | req_valid/ready    | action, key_id, key_hash, value_in
//  rsp     | out | rsp_valid/ready    | status, is_new, found, value_out
//  apb     | in  | psel/penable/pwrite| load_limit at byte address 0
//
//  An item passes from accept through the probe step, which reads P slots
//  (1..CAPACITY), to the commit step; a new request is accepted only in idle.
//  One slot per cycle through the single registered read port of the slot memories.
//  Get/delete on an empty table and unknown actions skip probing and go straight
//  from accept to the commit step.
//  After reset a clearing pass wipes every slot mark; req_ready is low during it.
//  A result waiting in the output register holds the block in its commit step.
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table #(
    parameter int CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lpht_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output lpht_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpht_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [IDX_W-1:0]  probe_idx_reg, probe_idx_next;
    logic [IDX_W-1:0]  probe_cnt_reg, probe_cnt_next;
    logic              have_tomb_reg, have_tomb_next;
    logic [IDX_W-1:0]  tomb_idx_reg, tomb_idx_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    commit_op_t        op_reg, op_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    rsp_t              res_reg, res_next;
    logic [8:0]        used_count_reg, used_count_next;
    logic [7:0]        load_limit_reg, load_limit_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    // Slot memories
    logic [31:0] key_mem  [CAPACITY];
    logic [63:0] val_mem  [CAPACITY];
    logic [1:0]  mark_mem [CAPACITY];

    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_key;
    logic [63:0]      rd_val;
    logic [1:0]       rd_mark;

    logic             key_we, val_we, mark_we;
    logic [IDX_W-1:0] mark_waddr;
    logic [1:0]       mark_wdata;

    logic             occ, tomb_here, hit, empty, last;
    logic             have_any, land_tomb, land_ok;
    logic [IDX_W-1:0] landing;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[slot_reg] <= req_reg.key_id;
        end
        rd_key <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[slot_reg] <= req_reg.value_in;
        end
        rd_val <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        rd_mark <= mark_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            used_count_reg <= '0;
            load_limit_reg <= LOAD_LIMIT_RST;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            used_count_reg <= used_count_next;
            load_limit_reg <= load_limit_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        probe_idx_reg <= probe_idx_next;
        probe_cnt_reg <= probe_cnt_next;
        have_tomb_reg <= have_tomb_next;
        tomb_idx_reg  <= tomb_idx_next;
        op_reg        <= op_next;
        slot_reg      <= slot_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    // Probe evaluation of the slot read in the previous cycle
    always_comb
    begin
        occ       = rd_mark[0];
        tomb_here = !rd_mark[0] && rd_mark[1];
        hit       = occ && (rd_key == req_reg.key_id);
        empty     = !rd_mark[0] && !rd_mark[1];
        last      = (probe_cnt_reg == IDX_LAST);
        have_any  = have_tomb_reg || tomb_here;
        land_tomb = have_any;
        land_ok   = empty || have_any;
        landing   = have_tomb_reg ? tomb_idx_reg : probe_idx_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        probe_idx_next  = probe_idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        have_tomb_next  = have_tomb_reg;
        tomb_idx_next   = tomb_idx_reg;
        clr_idx_next    = clr_idx_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        res_next        = res_reg;
        used_count_next = used_count_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        req_ready       = 1'b0;
        rd_addr         = probe_idx_reg + IDX_W'(1);
        key_we          = 1'b0;
        val_we          = 1'b0;
        mark_we         = 1'b0;
        mark_waddr      = slot_reg;
        mark_wdata      = (op_reg == CMT_INSERT) ? MARK_OCC : MARK_TOMB;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mark_we      = 1'b1;
                mark_waddr   = clr_idx_reg;
                mark_wdata   = MARK_EMPTY;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                req_ready = 1'b1;
                rd_addr   = req.key_hash[IDX_W-1:0];
                if (req_valid)
                begin
                    req_next       = req;
                    probe_idx_next = req.key_hash[IDX_W-1:0];
                    probe_cnt_next = '0;
                    have_tomb_next = 1'b0;
                    op_next        = CMT_NONE;
                    res_next       = '{status: STS_NOT_FOUND, is_new: 1'b0,
                                       found: 1'b0, value_out: 64'd0};
                    if (req.action == ACT_SET ||
                        ((req.action == ACT_GET || req.action == ACT_DEL) &&
                         used_count_reg != 9'd0))
                    begin
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end

            ST_PROBE:
            begin
                if (tomb_here && !have_tomb_reg)
                begin
                    have_tomb_next = 1'b1;
                    tomb_idx_next  = probe_idx_reg;
                end
                if (hit || empty || last)
                begin
                    state_next = ST_COMMIT;
                    unique case (req_reg.action)
                        ACT_SET:
                        begin
                            priority if (hit)
                            begin
                                op_next         = CMT_VALUE;
                                slot_next       = probe_idx_reg;
                                res_next.status = STS_DONE;
                            end
                            else if (!land_ok)
                            begin
                                res_next.status = STS_FULL;
                            end
                            else if (land_tomb)
                            begin
                                op_next         = CMT_INSERT;
                                slot_next       = landing;
                                res_next.status = STS_DONE;
                                res_next.is_new = 1'b1;
                            end
                            else if ((used_count_reg + 9'd1) > {1'b0, load_limit_reg})
                            begin
                                res_next.status = STS_FULL;
                            end
                            else
                            begin
                                op_next         = CMT_INSERT;
                                slot_next       = landing;
                                used_count_next = used_count_reg + 9'd1;
                                res_next.status = STS_DONE;
                                res_next.is_new = 1'b1;
                            end
                        end
                        ACT_GET:
                        begin
                            if (hit)
                            begin
                                res_next.status    = STS_DONE;
                                res_next.found     = 1'b1;
                                res_next.value_out = rd_val;
                            end
                        end
                        ACT_DEL:
                        begin
                            if (hit)
                            begin
                                op_next         = CMT_DELETE;
                                slot_next       = probe_idx_reg;
                                res_next.status = STS_DONE;
                                res_next.found  = 1'b1;
                            end
                        end
                        default:
                        begin
                            op_next = CMT_NONE;
                        end
                    endcase
                end
                else
                begin
                    probe_idx_next = probe_idx_reg + IDX_W'(1);
                    probe_cnt_next = probe_cnt_reg + IDX_W'(1);
                end
            end

            ST_COMMIT:
            begin
                // Writes repeat harmlessly while the result waits
                key_we  = (op_reg == CMT_INSERT);
                val_we  = (op_reg == CMT_INSERT) || (op_reg == CMT_VALUE);
                mark_we = (op_reg == CMT_INSERT) || (op_reg == CMT_DELETE);
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Register port
    always_comb
    begin
        load_limit_next = load_limit_reg;
        if (psel && penable && pwrite && paddr[2] == REG_LOAD_LIMIT)
        begin
            load_limit_next = pwdata[7:0];
        end
        prdata = (paddr[2] == REG_LOAD_LIMIT) ? {24'd0, load_limit_reg} : 32'd0;
        pready = 1'b1;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `LPHT_ASSERT_NOW(a_used_bounded, 1'b1, used_count_reg <= 9'd255, "used count above 255")
    `LPHT_ASSERT_NOW(a_used_step, used_count_reg != $past(used_count_reg),
        $past(state_reg) == ST_PROBE && used_count_reg == $past(used_count_reg) + 9'd1,
        "used count moved outside a probe end")
    `LPHT_ASSERT_NOW(a_rsp_from_commit, $rose(rsp_valid_reg), $past(state_reg) == ST_COMMIT,
        "result loaded outside commit")
    `LPHT_ASSERT_NEXT(a_accept_busy, req_valid && req_ready,
        state_reg == ST_PROBE || state_reg == ST_COMMIT, "accept did not start work")

endmodule

>>> tb/linear_probe_hash_table_test.sv
// Self-checking testbench for the linear probing hash table: directed script, random phases.
`timescale 1ns / 100ps

module linear_probe_hash_table_test;
    import lpht_pkg::*;

    localparam int CAP = 256;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_LOAD_LIMIT, 2'b00};
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES = 300;
    localparam int PRINT_CAP = 50;

    typedef enum {ROW_BEAT, ROW_LIMIT} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        req_t        beat;
        bit          known;
        rsp_t        want;
        logic [7:0]  limit;
    } script_row_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] hash;
    } key_ref_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_t                rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Shadow copy of the table contents and the limit register
    logic [31:0]  shadow_key [CAP];
    logic [63:0]  shadow_val [CAP];
    bit           shadow_occ [CAP];
    bit           shadow_tomb [CAP];
    logic [8:0]   shadow_used;
    logic [7:0]   shadow_limit;

    rsp_t         replies_due [$];
    script_row_t  script [$];
    key_ref_t     key_pool [$];
    int           mismatch_count;
    int           send_idle_pct;
    int           stall_pct;
    int           hold_ask;
    int           hold_seen;
    int           hold_left;
    logic [7:0]   cluster_base;

    linear_probe_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // Walk the probe path the way the table does and apply the request to the shadow copy.
    function automatic rsp_t compute_table_reply(input req_t r);
        rsp_t        o;
        logic [7:0]  idx;
        logic [7:0]  land;
        logic [7:0]  tomb;
        bit          done;
        bit          hit;
        bit          ok;
        bit          have_tomb;
        int          n;
        o = '0;
        o.status = STS_NOT_FOUND;
        idx = r.key_hash[7:0];
        land = '0;
        tomb = '0;
        done = 1'b0;
        hit = 1'b0;
        ok = 1'b0;
        have_tomb = 1'b0;
        if (r.action == ACT_SET || ((r.action == ACT_GET || r.action == ACT_DEL)
                                    && shadow_used != 0))
        begin
            for (n = 0; n < CAP && !done; n++)
            begin
                if (shadow_occ[idx])
                begin
                    if (shadow_key[idx] == r.key_id)
                    begin
                        hit = 1'b1;
                        ok = 1'b1;
                        land = idx;
                        done = 1'b1;
                    end
                end
                else if (shadow_tomb[idx])
                begin
                    if (!have_tomb)
                    begin
                        have_tomb = 1'b1;
                        tomb = idx;
                    end
                end
                else
                begin
                    land = have_tomb ? tomb : idx;
                    ok = 1'b1;
                    done = 1'b1;
                end
                idx = idx + 8'd1;
            end
            if (!done)
            begin
                land = tomb;
                ok = have_tomb;
            end
        end
        if (r.action == ACT_SET)
        begin
            if (hit)
            begin
                shadow_val[land] = r.value_in;
                o.status = STS_DONE;
            end
            else if (!ok)
                o.status = STS_FULL;
            else if (shadow_tomb[land])
            begin
                shadow_tomb[land] = 1'b0;
                shadow_occ[land] = 1'b1;
                shadow_key[land] = r.key_id;
                shadow_val[land] = r.value_in;
                o.status = STS_DONE;
                o.is_new = 1'b1;
            end
            else if (int'(shadow_used) + 1 > int'(shadow_limit))
                o.status = STS_FULL;
            else
            begin
                shadow_occ[land] = 1'b1;
                shadow_key[land] = r.key_id;
                shadow_val[land] = r.value_in;
                shadow_used = shadow_used + 9'd1;
                o.status = STS_DONE;
                o.is_new = 1'b1;
            end
        end
        else if ((r.action == ACT_GET || r.action == ACT_DEL) && hit)
        begin
            o.status = STS_DONE;
            o.found = 1'b1;
            if (r.action == ACT_GET)
                o.value_out = shadow_val[land];
            else
            begin
                shadow_occ[land] = 1'b0;
                shadow_tomb[land] = 1'b1;
            end
        end
        return o;
    endfunction

    task automatic offer_beat(input req_t beat, input bit known, input rsp_t known_rsp);
        rsp_t due;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        due = compute_table_reply(beat);
        replies_due.push_back(known ? known_rsp : due);
    endtask

    // Drop valid and hold until every outstanding result has been taken.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // APB write of load_limit followed by a read back.
    task automatic write_limit(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        shadow_limit = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata[7:0] !== value)
            flag_mismatch("load_limit read back", 64'(prdata), 64'(value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void add_beat(input logic [1:0] act, input logic [31:0] id,
                                     input logic [31:0] hash, input logic [63:0] value);
        script_row_t row;
        row.kind = ROW_BEAT;
        row.beat = '{action: act, key_id: id, key_hash: hash, value_in: value};
        row.known = 1'b0;
        row.want = '0;
        row.limit = '0;
        script.push_back(row);
    endfunction

    function automatic void add_known(input logic [1:0] act, input logic [31:0] id,
                                      input logic [31:0] hash, input logic [63:0] value,
                                      input logic [1:0] st, input logic nw, input logic fd,
                                      input logic [63:0] vo);
        script_row_t row;
        row.kind = ROW_BEAT;
        row.beat = '{action: act, key_id: id, key_hash: hash, value_in: value};
        row.known = 1'b1;
        row.want = '{status: st, is_new: nw, found: fd, value_out: vo};
        row.limit = '0;
        script.push_back(row);
    endfunction

    function automatic void add_limit(input logic [7:0] value);
        script_row_t row;
        row.kind = ROW_LIMIT;
        row.beat = '0;
        row.known = 1'b0;
        row.want = '0;
        row.limit = value;
        script.push_back(row);
    endfunction

    function automatic key_ref_t fresh_key(input int window);
        key_ref_t k;
        k.id = $urandom();
        if (k.id == 0)
            k.id = 32'd1;
        k.hash = $urandom();
        k.hash[7:0] = 8'(cluster_base + $urandom_range(0, window - 1));
        return k;
    endfunction

    // Mostly well-formed traffic on a pool of known keys, plus noise and wrong hashes.
    function automatic req_t draw_request(input int window, input int set_pct,
                                          input int fresh_pct);
        req_t      r;
        key_ref_t  k;
        int        roll;
        roll = $urandom_range(0, 99);
        r.value_in = {$urandom(), $urandom()};
        if (roll < 4)
        begin
            r.action = ACT_UNUSED;
            r.key_id = $urandom();
            r.key_hash = $urandom();
        end
        else if (roll < 10)
        begin
            r.action = 2'($urandom_range(0, 2));
            r.key_id = $urandom();
            r.key_hash = $urandom();
        end
        else
        begin
            if ($urandom_range(0, 99) < set_pct)
                r.action = ACT_SET;
            else
                r.action = $urandom_range(0, 1) ? ACT_GET : ACT_DEL;
            if (key_pool.size() == 0 ||
                (r.action == ACT_SET && $urandom_range(0, 99) < fresh_pct))
            begin
                k = fresh_key(window);
                if (key_pool.size() < 1024)
                    key_pool.push_back(k);
            end
            else
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            r.key_id = k.id;
            r.key_hash = k.hash;
            // wrong hash for a known key
            if (roll < 14)
                r.key_hash = $urandom();
        end
        return r;
    endfunction

    task automatic run_phase(input int n_items, input int s_pct, input int r_pct,
                             input int window, input int set_pct, input int fresh_pct);
        req_t r;
        send_idle_pct = s_pct;
        stall_pct = r_pct;
        cluster_base = 8'($urandom_range(0, 255));
        repeat (n_items)
        begin
            r = draw_request(window, set_pct, fresh_pct);
            offer_beat(r, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        rsp_ready = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (replies_due.size() == 0)
                flag_mismatch("result beat with nothing due", rsp.value_out, 64'd0);
            else
            begin
                want = replies_due.pop_front();
                if (rsp.status !== want.status)
                    flag_mismatch("status", 64'(rsp.status), 64'(want.status));
                if (rsp.is_new !== want.is_new)
                    flag_mismatch("is_new", 64'(rsp.is_new), 64'(want.is_new));
                if (rsp.found !== want.found)
                    flag_mismatch("found", 64'(rsp.found), 64'(want.found));
                if (rsp.value_out !== want.value_out)
                    flag_mismatch("value_out", rsp.value_out, want.value_out);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatch_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_ask = 0;
        cluster_base = '0;
        shadow_used = '0;
        shadow_limit = LOAD_LIMIT_RST;
        for (int i = 0; i < CAP; i++)
        begin
            shadow_occ[i] = 1'b0;
            shadow_tomb[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_val[i] = '0;
        end

        // Empty table, extremes, collisions with wrap, tombstones, load limit
        add_known(ACT_GET, 32'd5, 32'd0, 64'd0, STS_NOT_FOUND, 1'b0, 1'b0, 64'd0);
        add_known(ACT_DEL, 32'd5, 32'd0, '1, STS_NOT_FOUND, 1'b0, 1'b0, 64'd0);
        add_known(ACT_UNUSED, 32'd7, 32'd7, 64'd7, STS_NOT_FOUND, 1'b0, 1'b0, 64'd0);
        add_known(ACT_SET, '1, '1, '1, STS_DONE, 1'b1, 1'b0, 64'd0);
        add_known(ACT_GET, '1, '1, 64'd0, STS_DONE, 1'b0, 1'b1, '1);
        add_beat(ACT_SET, 32'd0, 32'd0, 64'd0);
        add_beat(ACT_GET, 32'd0, 32'd0, '1);
        add_beat(ACT_SET, 32'h11, 32'h0000_00FF, 64'h5555_5555_AAAA_AAAA);
        add_beat(ACT_GET, 32'h11, 32'h0000_00FF, 64'd0);
        add_known(ACT_SET, '1, '1, 64'h1234, STS_DONE, 1'b0, 1'b0, 64'd0);
        add_known(ACT_DEL, '1, '1, 64'd0, STS_DONE, 1'b0, 1'b1, 64'd0);
        add_beat(ACT_GET, 32'h11, 32'h0000_00FF, 64'd0);
        add_beat(ACT_SET, 32'h22, 32'h8000_00FF, 64'h0123_4567_89AB_CDEF);
        add_beat(ACT_DEL, 32'h99, 32'h7FFF_FF80, 64'd0);
        add_beat(ACT_GET, '1, '1, 64'd0);
        add_limit(8'd4);
        add_beat(ACT_SET, 32'h33, 32'h0000_0040, 64'd3);
        add_known(ACT_SET, 32'h44, 32'h0000_0041, 64'd4, STS_FULL, 1'b0, 1'b0, 64'd0);
        add_beat(ACT_DEL, 32'h33, 32'h0000_0040, 64'd0);
        add_beat(ACT_SET, 32'h55, 32'h0000_0040, 64'd5);
        add_limit(8'd1);
        add_known(ACT_SET, 32'h66, 32'h0000_0010, 64'd6, STS_FULL, 1'b0, 1'b0, 64'd0);
        add_beat(ACT_SET, 32'h22, 32'hFFFF_FFFF, '1);
        add_beat(ACT_GET, 32'h22, 32'h0000_00FF, 64'd0);
        add_known(ACT_UNUSED, '1, '1, '1, STS_NOT_FOUND, 1'b0, 1'b0, 64'd0);
        add_limit(8'd255);
        add_beat(ACT_GET, 32'h55, 32'h1234_5640, 64'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == ROW_LIMIT)
            begin
                wait_drained();
                write_limit(script[i].limit);
            end
            else
                offer_beat(script[i].beat, script[i].known, script[i].want);
        end

        wait_drained();
        write_limit(LOAD_LIMIT_RST);
        // long receiver hold-off while the sender keeps offering
        hold_ask = hold_ask + 1;
        run_phase(60, 0, 0, 16, 45, 50);

        wait_drained();
        write_limit(8'd16);
        run_phase(50, 64, 0, 16, 45, 40);

        // fill toward the top limit, then work on a nearly full table
        wait_drained();
        write_limit(8'd255);
        run_phase(300, 0, 64, 256, 95, 100);
        run_phase(70, 7, 7, 256, 40, 30);

        wait_drained();
        write_limit(8'd1);
        run_phase(50, 0, 0, 16, 45, 50);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
